[hdl/positional_pid_controller_assert.svh]
// Assertion macros for the positional PID controller
`ifndef POSITIONAL_PID_CONTROLLER_ASSERT_SVH
`define POSITIONAL_PID_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PPID_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppid assertion failed");

// Next-cycle implication, checked outside reset
`define PPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppid assertion failed");

`endif

[hdl/ppid_pkg.sv]
// Shared widths, codes and types of the positional PID controller
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

   localparam int DATA_W    = 32;              // Q16.16 sample, gain and output width
   localparam int LIM_W     = 31;              // unsigned limit / dead zone width
   localparam int EXT_W     = DATA_W + 1;      // error, integral, derivative at 33 bits
   localparam int FRAC_W    = 16;              // fraction bits of Q16.16
   localparam int FULL_W    = DATA_W + EXT_W;  // full product width
   localparam int PROD_W    = FULL_W - FRAC_W; // product after the floor shift
   localparam int SUM_W     = PROD_W + 2;      // sum of three products
   localparam int CSR_IDX_W = 3;

   typedef enum logic {
      OP_STEP  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INTEG_GAIN  = 3'd1,
      CSR_DERIV_GAIN  = 3'd2,
      CSR_INTEG_LIMIT = 3'd3,
      CSR_DEAD_ZONE   = 3'd4,
      CSR_OUT_LIMIT   = 3'd5
   } csr_idx_type;

endpackage

`default_nettype wire

[hdl/ppid_mul.sv]
// Registered signed gain product with Q16.16 floor shift
`timescale 1ns / 1ps
`default_nettype none

module ppid_mul (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [ppid_pkg::DATA_W-1:0]  gain,
   input  logic signed [ppid_pkg::EXT_W-1:0]   operand,
   output logic signed [ppid_pkg::PROD_W-1:0]  product
);
   import ppid_pkg::*;

   logic signed [FULL_W-1:0] full_prod;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   always_comb begin
      full_prod = FULL_W'(gain) * FULL_W'(operand);
      // dropping the low bits of a two's complement value rounds toward minus infinity
      prod_in   = full_prod[FULL_W-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

[hdl/positional_pid_controller.sv]
// Top level of the positional PID controller with anti-windup
`timescale 1ns / 1ps
`default_nettype none
`include "positional_pid_controller_assert.svh"

// Positional PID regulator in signed Q16.16. Each item is either a step with an
// error sample or a clear. A step zeroes an error whose magnitude is at or below
// dead_zone, adds it to the integral (clamped to +/- integ_limit), takes the
// derivative against the previous error, and returns the sum of the three gain
// products (each floor-shifted by 16) clamped to +/- out_limit. A clear zeroes the
// integral and the previous error and returns zero. The block takes one item per
// cycle while req_stall is low, through input register, prep stage, product stage
// and result register. The integral / previous-error feedback closes within the
// prep stage; the three 32x33 multipliers sit in their own stage. Each stage moves
// on when the next one is empty or moving, so input keeps flowing while a result
// waits on rsp_stall until every stage is full. Configuration registers (csr_index
// 0..5: prop_gain, integ_gain, deriv_gain, integ_limit, dead_zone, out_limit) must
// be written by the user only while the block is idle, which the block does not
// enforce; other indexes are ignored. Config, state and valid flags reset to zero.
module positional_pid_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic signed [ppid_pkg::DATA_W-1:0]    req_error_in,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ppid_pkg::DATA_W-1:0]    rsp_control_out,
   // configuration
   input  logic                                  csr_wen,
   input  logic [ppid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ppid_pkg::DATA_W-1:0]           csr_wdata
);
   import ppid_pkg::*;

   // ---- configuration registers ----
   logic signed [DATA_W-1:0] prop_gain_ff;
   logic signed [DATA_W-1:0] integ_gain_ff;
   logic signed [DATA_W-1:0] deriv_gain_ff;
   logic [LIM_W-1:0]         integ_limit_ff;
   logic [LIM_W-1:0]         dead_zone_ff;
   logic [LIM_W-1:0]         out_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         integ_limit_ff <= '0;
         dead_zone_ff   <= '0;
         out_limit_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_idx_type'(csr_index))
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata;
            CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wdata;
            CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata;
            CSR_INTEG_LIMIT: integ_limit_ff <= csr_wdata[LIM_W-1:0];
            CSR_DEAD_ZONE:   dead_zone_ff   <= csr_wdata[LIM_W-1:0];
            CSR_OUT_LIMIT:   out_limit_ff   <= csr_wdata[LIM_W-1:0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   // ---- pipeline flow control ----
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic rsp_ready, s2_ready, s1_ready, s0_ready;
   logic take_req, mv1, mv2, mv3;

   always_comb begin
      rsp_ready = !rsp_valid_ff || !rsp_stall;
      s2_ready  = !s2_valid_ff  || rsp_ready;
      s1_ready  = !s1_valid_ff  || s2_ready;
      s0_ready  = !s0_valid_ff  || s1_ready;
      take_req  = req_valid && s0_ready;
      mv1       = s0_valid_ff && s1_ready;
      mv2       = s1_valid_ff && s2_ready;
      mv3       = s2_valid_ff && rsp_ready;
   end

   assign req_stall = !s0_ready;
   assign rsp_valid = rsp_valid_ff;

   logic s0_valid_in, s1_valid_in, s2_valid_in, rsp_valid_in;

   always_comb begin
      s0_valid_in  = take_req || (s0_valid_ff && !mv1);
      s1_valid_in  = mv1      || (s1_valid_ff && !mv2);
      s2_valid_in  = mv2      || (s2_valid_ff && !mv3);
      rsp_valid_in = mv3      || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- stage 0: input register ----
   op_type                   s0_op_ff;
   logic signed [DATA_W-1:0] s0_err_ff;

   always_ff @(posedge clock) begin
      if (take_req) begin
         s0_op_ff  <= op_type'(req_operation);
         s0_err_ff <= req_error_in;
      end
   end

   // ---- stage 1: dead zone, integral clamp, derivative, state update ----
   logic signed [DATA_W-1:0] integ_sum_ff, integ_sum_in;
   logic signed [DATA_W-1:0] prev_error_ff, prev_error_in;

   logic signed [EXT_W-1:0] err_ext, dz_ext, lim_ext, isum_raw, integ_clamped;
   logic signed [DATA_W-1:0] err_dz;
   logic signed [EXT_W-1:0] err_in, integ_in, deriv_in;
   logic                    in_dead_zone;

   always_comb begin
      err_ext      = {s0_err_ff[DATA_W-1], s0_err_ff};
      dz_ext       = signed'({2'b00, dead_zone_ff});
      lim_ext      = signed'({2'b00, integ_limit_ff});
      in_dead_zone = (err_ext <= dz_ext) && (err_ext >= -dz_ext);
      err_dz       = in_dead_zone ? '0 : s0_err_ff;

      // integral kept inside +/- integ_limit after every addition
      isum_raw = {integ_sum_ff[DATA_W-1], integ_sum_ff} + {err_dz[DATA_W-1], err_dz};
      if (isum_raw > lim_ext) begin
         integ_clamped = lim_ext;
      end else if (isum_raw < -lim_ext) begin
         integ_clamped = -lim_ext;
      end else begin
         integ_clamped = isum_raw;
      end

      if (s0_op_ff == OP_CLEAR) begin
         // all terms zero, so the item yields zero downstream
         err_in        = '0;
         integ_in      = '0;
         deriv_in      = '0;
         integ_sum_in  = '0;
         prev_error_in = '0;
      end else begin
         err_in        = {err_dz[DATA_W-1], err_dz};
         integ_in      = integ_clamped;
         deriv_in      = {err_dz[DATA_W-1], err_dz}
                       - {prev_error_ff[DATA_W-1], prev_error_ff};
         integ_sum_in  = integ_clamped[DATA_W-1:0];
         prev_error_in = err_dz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_sum_ff  <= '0;
         prev_error_ff <= '0;
      end else if (mv1) begin
         integ_sum_ff  <= integ_sum_in;
         prev_error_ff <= prev_error_in;
      end
   end

   logic signed [EXT_W-1:0] s1_err_ff, s1_integ_ff, s1_deriv_ff;

   always_ff @(posedge clock) begin
      if (mv1) begin
         s1_err_ff   <= err_in;
         s1_integ_ff <= integ_in;
         s1_deriv_ff <= deriv_in;
      end
   end

   // ---- stage 2: gain products ----
   logic signed [PROD_W-1:0] p_term, i_term, d_term;

   ppid_mul u_mul_p (
      .clock   (clock),
      .load    (mv2),
      .gain    (prop_gain_ff),
      .operand (s1_err_ff),
      .product (p_term)
   );

   ppid_mul u_mul_i (
      .clock   (clock),
      .load    (mv2),
      .gain    (integ_gain_ff),
      .operand (s1_integ_ff),
      .product (i_term)
   );

   ppid_mul u_mul_d (
      .clock   (clock),
      .load    (mv2),
      .gain    (deriv_gain_ff),
      .operand (s1_deriv_ff),
      .product (d_term)
   );

   // ---- stage 3: sum, output clamp, result register ----
   logic signed [SUM_W-1:0]  pid_sum, olim_ext, olim_neg;
   logic signed [DATA_W-1:0] ctrl_in;
   logic signed [DATA_W-1:0] rsp_ctrl_ff;

   always_comb begin
      pid_sum  = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
      olim_ext = signed'(SUM_W'(out_limit_ff));
      olim_neg = -olim_ext;
      if (pid_sum > olim_ext) begin
         ctrl_in = olim_ext[DATA_W-1:0];
      end else if (pid_sum < olim_neg) begin
         ctrl_in = olim_neg[DATA_W-1:0];
      end else begin
         ctrl_in = pid_sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mv3) begin
         rsp_ctrl_ff <= ctrl_in;
      end
   end

   assign rsp_control_out = rsp_ctrl_ff;

   // ---- assertions ----
   // a clear leaves no integral and no history behind
   `PPID_ASSERT_NEXT(a_clear_zeroes_state, clock, reset,
      mv1 && (s0_op_ff == OP_CLEAR), (integ_sum_ff == '0) && (prev_error_ff == '0))
   // the history register follows the error sent down the pipe
   `PPID_ASSERT_NEXT(a_prev_tracks_err, clock, reset,
      mv1, prev_error_ff == s1_err_ff[DATA_W-1:0])
   // input stalls only when every stage is full and the result is held
   `PPID_ASSERT_IMPLY(a_stall_only_full, clock, reset,
      req_stall, s0_valid_ff && s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall)
   // a held result is never overwritten by the product stage
   `PPID_ASSERT_IMPLY(a_no_overwrite, clock, reset,
      rsp_valid_ff && rsp_stall, !mv3)

endmodule

`default_nettype wire
